// File: src/afrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrm_pkg
// Shared constants and types for the adaptive frame rate meter.
// ----------------------------------------------------------------------------
package afrm_pkg;

	localparam int MAX_SAMPLES_DEF = 255;
	localparam int TIME_BITS_DEF   = 32;
	localparam int QUEUE_DEPTH     = 4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_FAST_WINDOW = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_WINDOW = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_RATE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BITS_LIMIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BITRATE = 3'd4;

	localparam logic [15:0] FAST_WINDOW_RST = 16'd50;
	localparam logic [15:0] SLOW_WINDOW_RST = 16'd80;
	localparam logic [31:0] START_RATE_RST  = 32'd0;
	localparam logic [15:0] BITS_LIMIT_RST  = 16'd256;
	localparam logic [15:0] MAX_BITRATE_RST = 16'd1;

	// frames * RATE_SCALE fits in RATE_NUM_W bits for up to 255 frames
	localparam int          RATE_NUM_W = 25;
	localparam logic [16:0] RATE_SCALE = 17'd100000;
	localparam int          STEP_NUM_W = 40;
	localparam int          STEP_W     = 31;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// File: src/adaptive_frame_rate_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_frame_rate_meter
// Per-frame timestamp in, smoothed frame rate and step count out.
// ----------------------------------------------------------------------------
// Each frame passes the queue hand-off and, when it closes a period, the
//   rate divider and average update, then the multiply and the step
//   divider before its result is valid.
// The shared rate engine takes one frame at a time and starts the next
//   only after a result is handed off; the 4-entry queue absorbs bursts.
// Reset: asynchronous, clears counters and loads the register defaults.
module adaptive_frame_rate_meter #(
	parameter int MAX_SAMPLES = afrm_pkg::MAX_SAMPLES_DEF,
	parameter int TIME_BITS   = afrm_pkg::TIME_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [31:0]                         frame_time_ms,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                rate_updated,
	output logic [31:0]                         avg_rate_x100,
	output logic [afrm_pkg::STEP_W-1:0]         step_count,
	output logic [7:0]                          sample_target_now,
	input  logic                                cfg_we,
	input  logic [afrm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [afrm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int QW = TIME_BITS + 17;

	logic [15:0] fast_window_q;
	logic [15:0] slow_window_q;
	logic [15:0] bits_limit_q;
	logic [15:0] max_bitrate_q;

	afrm_pkg::q_stat_t q_stat;
	logic              push;
	logic              pop;
	logic [QW-1:0]     push_data;
	logic [QW-1:0]     pop_data;
	logic              avg_load;

	assign in_stall = q_stat.full;
	assign avg_load = cfg_we && (cfg_index == afrm_pkg::CFG_START_RATE);

	// start rate goes straight into the average on its write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_window_q <= afrm_pkg::FAST_WINDOW_RST;
			slow_window_q <= afrm_pkg::SLOW_WINDOW_RST;
			bits_limit_q  <= afrm_pkg::BITS_LIMIT_RST;
			max_bitrate_q <= afrm_pkg::MAX_BITRATE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				afrm_pkg::CFG_FAST_WINDOW: fast_window_q <= cfg_data[15:0];
				afrm_pkg::CFG_SLOW_WINDOW: slow_window_q <= cfg_data[15:0];
				afrm_pkg::CFG_START_RATE: begin
				end
				afrm_pkg::CFG_BITS_LIMIT:  bits_limit_q  <= cfg_data[15:0];
				afrm_pkg::CFG_MAX_BITRATE: max_bitrate_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	afrm_front #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.TIME_BITS   (TIME_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.frame_time_ms  (frame_time_ms),
		.fast_window_ms (fast_window_q),
		.slow_window_ms (slow_window_q),
		.q_stat         (q_stat),
		.push           (push),
		.push_data      (push_data)
	);

	afrm_queue #(
		.WIDTH (QW),
		.DEPTH (afrm_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	afrm_back #(
		.TIME_BITS (TIME_BITS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_stat            (q_stat),
		.pop_data          (pop_data),
		.pop               (pop),
		.avg_load          (avg_load),
		.start_rate_x100   (cfg_data[31:0]),
		.bits_at_limit_q8  (bits_limit_q),
		.max_bitrate       (max_bitrate_q),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.rate_updated      (rate_updated),
		.avg_rate_x100     (avg_rate_x100),
		.step_count        (step_count),
		.sample_target_now (sample_target_now)
	);

	a_step_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (step_count != '0))
		else $error("step count of zero on a valid request");

	a_queue_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty at once");

	a_out_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> !out_valid)
		else $error("result shown again right after hand-off");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!out_valid && !q_stat.empty))
		else $error("queue popped while engine busy or queue empty");

endmodule

// File: src/afrm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrm_queue
// Small register FIFO between the frame classifier and the rate engine.
// ----------------------------------------------------------------------------
module afrm_queue #(
	parameter int WIDTH = 49,
	parameter int DEPTH = afrm_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [WIDTH-1:0]    push_data,
	input  logic                pop,
	output logic [WIDTH-1:0]    pop_data,
	output afrm_pkg::q_stat_t   stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: src/afrm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrm_front
// Counts frames, closes sampling periods, adapts the sample target and
// queues one command per frame for the rate engine.
// ----------------------------------------------------------------------------
module afrm_front #(
	parameter int MAX_SAMPLES = afrm_pkg::MAX_SAMPLES_DEF,
	parameter int TIME_BITS   = afrm_pkg::TIME_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [31:0]            frame_time_ms,
	input  logic [15:0]            fast_window_ms,
	input  logic [15:0]            slow_window_ms,
	input  afrm_pkg::q_stat_t      q_stat,
	output logic                   push,
	output logic [TIME_BITS+16:0]  push_data
);

	localparam int          CW   = (TIME_BITS > 16) ? TIME_BITS : 16;
	localparam logic [7:0]  TCAP = 8'((MAX_SAMPLES > 255) ? 255 : MAX_SAMPLES);

	logic [7:0]           frames_q;
	logic [7:0]           target_q;
	logic [TIME_BITS-1:0] start_q;

	logic [TIME_BITS-1:0] now;
	logic [TIME_BITS-1:0] delta;
	logic [7:0]           frames_nx;
	logic [7:0]           target_nx;
	logic                 at_target;
	logic                 closed;

	assign push = in_valid && !q_stat.full;
	assign now  = TIME_BITS'(frame_time_ms);

	always_comb begin
		frames_nx = (frames_q != 8'hFF) ? frames_q + 8'd1 : frames_q;
		at_target = (frames_nx == target_q);
		delta     = now - start_q;
		target_nx = target_q;
		if (at_target) begin
			if (CW'(delta) < CW'(fast_window_ms)) begin
				if (target_q < TCAP) begin
					target_nx = target_q + 8'd1;
				end
			end else if (CW'(delta) > CW'(slow_window_ms)) begin
				target_nx = (target_q > 8'd2) ? target_q - 8'd1 : 8'd2;
			end
		end
		closed = at_target && (delta != '0);
	end

	assign push_data = {closed, frames_nx, target_nx, delta};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= '0;
			target_q <= 8'd1;
			start_q  <= '0;
		end else if (push) begin
			target_q <= target_nx;
			if (closed) begin
				frames_q <= '0;
				start_q  <= now;
			end else begin
				frames_q <= frames_nx;
			end
		end
	end

endmodule

// File: src/afrm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrm_back
// Rate engine: divides the closed period into a rate, smooths the average
// and derives the step count through a radix-4 divider.
// ----------------------------------------------------------------------------
module afrm_back #(
	parameter int TIME_BITS = afrm_pkg::TIME_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  afrm_pkg::q_stat_t                   q_stat,
	input  logic [TIME_BITS+16:0]               pop_data,
	output logic                                pop,
	input  logic                                avg_load,
	input  logic [31:0]                         start_rate_x100,
	input  logic [15:0]                         bits_at_limit_q8,
	input  logic [15:0]                         max_bitrate,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                rate_updated,
	output logic [31:0]                         avg_rate_x100,
	output logic [afrm_pkg::STEP_W-1:0]         step_count,
	output logic [7:0]                          sample_target_now
);

	localparam int NW       = afrm_pkg::RATE_NUM_W;
	localparam int SW       = afrm_pkg::STEP_NUM_W;
	localparam int STEP_W_L = afrm_pkg::STEP_W;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RDIV = 6'b000010,
		ST_AVG  = 6'b000100,
		ST_MUL  = 6'b001000,
		ST_SDIV = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t               state_q;
	logic [4:0]           cnt_q;
	logic [31:0]          avg_q;
	logic                 upd_q;
	logic [7:0]           target_q;
	logic [TIME_BITS-1:0] delta_q;
	logic [NW-1:0]        rnum_q;
	logic [NW-1:0]        rquo_q;
	logic [TIME_BITS-1:0] rrem_q;
	logic [SW-1:0]        snum_q;
	logic [SW-1:0]        squo_q;
	logic [15:0]          srem_q;
	logic [STEP_W_L-1:0]  step_q;

	logic                 e_upd;
	logic [7:0]           e_frames;
	logic [7:0]           e_target;
	logic [TIME_BITS-1:0] e_delta;

	logic [TIME_BITS:0]   r_sh;
	logic                 r_ge;
	logic [TIME_BITS:0]   r_diff;
	logic [32:0]          avg_sum;
	logic [15:0]          sdiv;
	logic [16:0]          s1_sh, s1_rem, s2_sh, s2_rem;
	logic                 s1_ge, s2_ge;
	logic [SW-1:0]        squo_nx;
	logic [STEP_W_L-1:0]  step_nx;

	assign {e_upd, e_frames, e_target, e_delta} = pop_data;
	assign pop       = (state_q == ST_IDLE) && !q_stat.empty;
	assign out_valid = (state_q == ST_DONE);

	always_comb begin
		r_sh   = {rrem_q, rnum_q[NW-1]};
		r_ge   = (r_sh >= {1'b0, delta_q});
		r_diff = r_sh - {1'b0, delta_q};

		avg_sum = {1'b0, avg_q} + 33'(rquo_q);

		sdiv   = (max_bitrate == '0) ? 16'd1 : max_bitrate;
		s1_sh  = {srem_q, snum_q[SW-1]};
		s1_ge  = (s1_sh >= {1'b0, sdiv});
		s1_rem = s1_ge ? s1_sh - {1'b0, sdiv} : s1_sh;
		s2_sh  = {s1_rem[15:0], snum_q[SW-2]};
		s2_ge  = (s2_sh >= {1'b0, sdiv});
		s2_rem = s2_ge ? s2_sh - {1'b0, sdiv} : s2_sh;

		squo_nx = {squo_q[SW-3:0], s1_ge, s2_ge};

		if (squo_nx[SW-1:STEP_W_L] != '0) begin
			step_nx = '1;
		end else if (squo_nx == '0) begin
			step_nx = STEP_W_L'(1);
		end else begin
			step_nx = squo_nx[STEP_W_L-1:0];
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				upd_q    <= e_upd;
				target_q <= e_target;
				delta_q  <= e_delta;
				rnum_q   <= NW'(e_frames) * NW'(afrm_pkg::RATE_SCALE);
				rquo_q   <= '0;
				rrem_q   <= '0;
			end
			ST_RDIV: begin
				rnum_q <= rnum_q << 1;
				rquo_q <= {rquo_q[NW-2:0], r_ge};
				rrem_q <= r_ge ? r_diff[TIME_BITS-1:0] : r_sh[TIME_BITS-1:0];
			end
			ST_MUL: begin
				snum_q <= SW'((48'(avg_q) * 48'(bits_at_limit_q8)) >> 8);
				squo_q <= '0;
				srem_q <= '0;
			end
			ST_SDIV: begin
				snum_q <= snum_q << 2;
				squo_q <= squo_nx;
				srem_q <= s2_rem[15:0];
				if (cnt_q == '0) begin
					rate_updated      <= upd_q;
					avg_rate_x100     <= avg_q;
					sample_target_now <= target_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign step_count = step_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_SDIV && cnt_q == '0) begin
			step_q <= step_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			avg_q   <= afrm_pkg::START_RATE_RST;
		end else begin
			if (avg_load) begin
				avg_q <= start_rate_x100;
			end else if (state_q == ST_AVG) begin
				avg_q <= avg_sum[32:1];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_stat.empty) begin
						cnt_q   <= 5'(NW - 1);
						state_q <= e_upd ? ST_RDIV : ST_MUL;
					end
				end
				ST_RDIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0) begin
						state_q <= ST_AVG;
					end
				end
				ST_AVG: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					cnt_q   <= 5'(SW / 2 - 1);
					state_q <= ST_SDIV;
				end
				ST_SDIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the adaptive frame rate meter. Frame timestamps go
// in through a valid/stall channel and every accepted request is run through
// a bench-side model of the period counter, the adaptive target and the
// rate/step arithmetic. Each result leaving the block is compared field by
// field with the oldest prediction. A short table of directed frames opens
// the run; configuration phases with random timestamps follow, including a
// zero-interval climb of the target to its cap and a stuck zero interval.
// ----------------------------------------------------------------------------
module tb_top;
	import afrm_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int TARGET_CAP  = (MAX_SAMPLES_DEF > 255) ? 255 : MAX_SAMPLES_DEF;

	typedef struct packed {
		logic              upd;
		logic [31:0]       avg;
		logic [STEP_W-1:0] steps;
		logic [7:0]        tgt;
	} meter_res_t;

	typedef struct packed {
		logic       given;
		meter_res_t want;
	} typed_res_t;

	typedef struct packed {
		logic [31:0] stamp;
		typed_res_t  tag;
	} frame_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [31:0]           frame_time_ms;
	logic                  out_valid;
	logic                  out_stall;
	logic                  rate_updated;
	logic [31:0]           avg_rate_x100;
	logic [STEP_W-1:0]     step_count;
	logic [7:0]            sample_target_now;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// configuration mirror
	logic [15:0] fast_ms;
	logic [15:0] slow_ms;
	logic [15:0] bits_q8;
	logic [15:0] max_br;

	// meter state mirror
	logic [7:0]  m_frames;
	logic [7:0]  m_target;
	logic [31:0] m_start;
	logic [31:0] m_avg;

	meter_res_t pending_results[$];
	typed_res_t typed_q[$];
	frame_row_t dir_rows [0:21];

	int          errors      = 0;
	int          cycle_count = 0;
	int          snd_idle_pct;
	int          rcv_idle_pct;
	logic [31:0] stamp;

	adaptive_frame_rate_meter u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.frame_time_ms     (frame_time_ms),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.rate_updated      (rate_updated),
		.avg_rate_x100     (avg_rate_x100),
		.step_count        (step_count),
		.sample_target_now (sample_target_now),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
	end

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			$display("mismatch %s at cycle %0d: got %0d want %0d",
				name, cycle_count, got, want);
			errors++;
		end
	endtask

	function automatic meter_res_t advance_meter(input logic [31:0] now);
		meter_res_t  r;
		logic [31:0] delta;
		logic [63:0] quot;
		logic [32:0] sum;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] steps;
		r.upd = 1'b0;
		if (m_frames != 8'hFF) m_frames++;
		if (m_frames == m_target) begin
			delta = now - m_start;
			if (delta < {16'd0, fast_ms}) begin
				if (m_target < TARGET_CAP) m_target++;
			end else if (delta > {16'd0, slow_ms}) begin
				if (m_target > 8'd2) m_target--;
				else m_target = 8'd2;
			end
			if (delta != 32'd0) begin
				quot = m_frames * 64'd100000 / delta;
				sum = {1'b0, m_avg} + quot[32:0];
				m_avg = sum[32:1];
				m_start = now;
				m_frames = 8'd0;
				r.upd = 1'b1;
			end
		end
		num = m_avg * bits_q8;
		den = (max_br == 16'd0) ? 64'd256 : {max_br, 8'd0};
		steps = num / den;
		if (steps > 64'h7FFF_FFFF) steps = 64'h7FFF_FFFF;
		if (steps < 64'd1) steps = 64'd1;
		r.avg = m_avg;
		r.steps = steps[STEP_W-1:0];
		r.tgt = m_target;
		return r;
	endfunction

	// scoreboard: results first, so a request accepted this edge is never matched here
	always @(posedge clk) begin : monitor
		meter_res_t want;
		meter_res_t pred;
		typed_res_t tag;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					check_field("result with nothing expected", 32'd1, 32'd0);
				end else begin
					want = pending_results.pop_front();
					check_field("rate_updated", 32'(rate_updated), 32'(want.upd));
					check_field("avg_rate_x100", avg_rate_x100, want.avg);
					check_field("step_count", 32'(step_count), 32'(want.steps));
					check_field("sample_target_now", 32'(sample_target_now),
						32'(want.tgt));
				end
			end
			if (in_valid && !in_stall) begin
				pred = advance_meter(frame_time_ms);
				tag = typed_q.pop_front();
				pending_results.push_back(tag.given ? tag.want : pred);
			end
		end
	end

	task automatic send_frame(input logic [31:0] t, input typed_res_t tag);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		typed_q.push_back(tag);
		in_valid <= 1'b1;
		frame_time_ms <= t;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_FAST_WINDOW: fast_ms = data[15:0];
			CFG_SLOW_WINDOW: slow_ms = data[15:0];
			CFG_START_RATE:  m_avg = data;
			CFG_BITS_LIMIT:  bits_q8 = data[15:0];
			CFG_MAX_BITRATE: max_br = data[15:0];
			default: ;
		endcase
	endtask

	function automatic logic [31:0] next_stamp(input logic [31:0] last, input int span);
		int pick;
		pick = $urandom_range(0, 99);
		// zero interval only where a short window lets the target recover
		if (pick < 8 && fast_ms != 16'd0) return last;
		if (pick < 14) return $urandom;
		if (pick < 18) return last + $urandom;
		return last + $urandom_range(1, span);
	endfunction

	// hold > 0: the first hold frames repeat the open period's timestamp
	task automatic run_phase(input int n, input int hold, input logic [15:0] fw,
			input logic [15:0] sw, input logic [31:0] sr, input logic [15:0] bl,
			input logic [15:0] mb);
		int span;
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_write(CFG_FAST_WINDOW, {16'd0, fw});
		cfg_write(CFG_SLOW_WINDOW, {16'd0, sw});
		cfg_write(CFG_START_RATE, sr);
		cfg_write(CFG_BITS_LIMIT, {16'd0, bl});
		cfg_write(CFG_MAX_BITRATE, {16'd0, mb});
		cfg_we <= 1'b0;
		span = sw / 2 + 2;
		if (span > 4000) span = 4000;
		if (hold > 0) stamp = m_start;
		for (int i = 0; i < n; i++) begin
			if (i >= hold) stamp = next_stamp(stamp, span);
			send_frame(stamp, '0);
		end
	endtask

	initial begin
		int rfw;
		int rsw;
		arst_n = 1'b0;
		in_valid = 1'b0;
		frame_time_ms = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		snd_idle_pct = 19;
		rcv_idle_pct = 46;
		fast_ms = FAST_WINDOW_RST;
		slow_ms = SLOW_WINDOW_RST;
		bits_q8 = BITS_LIMIT_RST;
		max_br = MAX_BITRATE_RST;
		m_frames = 8'd0;
		m_target = 8'd1;
		m_start = 32'd0;
		m_avg = START_RATE_RST;

		// first period between the windows keeps target 1, then zero intervals grow it
		dir_rows[0]  = {32'd60,  1'b1, 1'b1, 32'd833,  31'd833,  8'd1};
		dir_rows[1]  = {32'd60,  1'b1, 1'b0, 32'd833,  31'd833,  8'd2};
		dir_rows[2]  = {32'd60,  1'b1, 1'b0, 32'd833,  31'd833,  8'd3};
		dir_rows[3]  = {32'd160, 1'b1, 1'b1, 32'd1916, 31'd1916, 8'd2};
		dir_rows[4]  = {32'd170, 1'b1, 1'b0, 32'd1916, 31'd1916, 8'd2};
		dir_rows[5]  = {32'd180, 73'd0};
		dir_rows[6]  = {32'd181, 73'd0};
		dir_rows[7]  = {32'd182, 73'd0};
		dir_rows[8]  = {32'd183, 73'd0};
		dir_rows[9]  = {32'hFFFF_FFF0, 73'd0};
		dir_rows[10] = {32'hFFFF_FFFF, 73'd0};
		dir_rows[11] = {32'h0000_0000, 73'd0};
		dir_rows[12] = {32'h0000_0005, 73'd0};
		dir_rows[13] = {32'h0000_0009, 73'd0};
		dir_rows[14] = {32'h8000_0000, 73'd0};
		dir_rows[15] = {32'h7FFF_FFFF, 73'd0};
		dir_rows[16] = {32'h5555_5555, 73'd0};
		dir_rows[17] = {32'hAAAA_AAAA, 73'd0};
		dir_rows[18] = {32'hAAAA_AAAA, 73'd0};
		dir_rows[19] = {32'hAAAA_AAAB, 73'd0};
		dir_rows[20] = {32'hAAAA_AAC0, 73'd0};
		dir_rows[21] = {32'hAAAA_AB40, 73'd0};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 22; i++) begin
			send_frame(dir_rows[i].stamp, dir_rows[i].tag);
		end
		stamp = dir_rows[21].stamp;

		run_phase(100, 0, 16'd100, 16'd200, 32'd12345, 16'd256, 16'd1);
		// step count saturates, every closed period shrinks the target
		run_phase(100, 0, 16'd0, 16'd0, 32'hFFFF_FFFF, 16'hFFFF, 16'd1);
		run_phase(100, 0, 16'hFFFF, 16'hFFFF, 32'd0, 16'd0, 16'hFFFF);

		snd_idle_pct = 46;
		rcv_idle_pct = 19;
		rfw = $urandom_range(1, 200);
		rsw = rfw + $urandom_range(0, 200);
		run_phase(100, 0, 16'(rfw), 16'(rsw), $urandom, 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)));
		// zero intervals walk the target up to its cap
		run_phase(300, 260, 16'd40, 16'd90, $urandom, 16'($urandom_range(0, 65535)),
			16'($urandom_range(1, 300)));
		run_phase(100, 0, 16'd30, 16'd30, 32'd0, 16'($urandom_range(0, 65535)), 16'd0);

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		rfw = $urandom_range(1, 400);
		rsw = rfw + $urandom_range(0, 400);
		run_phase(100, 0, 16'(rfw), 16'(rsw), $urandom, 16'($urandom_range(0, 65535)),
			16'($urandom_range(1, 20)));
		// zero interval with no fast window: the period never closes again
		run_phase(60, 40, 16'd0, 16'd70, $urandom, 16'($urandom_range(0, 65535)), 16'd3);

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (pending_results.size() != 0)
			check_field("results left over", 32'(pending_results.size()), 32'd0);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
